[rtl/core/rppt_pkg.sv]
`default_nettype none

package rppt_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 21;
  localparam int unsigned COEF_WIDTH_DEF  = 18;

  localparam int unsigned APB_DATA_WIDTH = 64;
  localparam int unsigned APB_ADDR_WIDTH = 6;
  localparam int unsigned REG_IDX_WIDTH  = 3;

  localparam logic [REG_IDX_WIDTH-1:0] REG_ROT_CURR_ROW0 = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_ROT_CURR_ROW1 = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_ROT_CURR_ROW2 = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_TRANS_CURR    = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_TRANS_PREV    = 3'd4;
  localparam logic [REG_IDX_WIDTH-1:0] REG_INV_PREV_ROW0 = 3'd5;
  localparam logic [REG_IDX_WIDTH-1:0] REG_INV_PREV_ROW1 = 3'd6;
  localparam logic [REG_IDX_WIDTH-1:0] REG_INV_PREV_ROW2 = 3'd7;

endpackage

`default_nettype wire

[rtl/core/rppt_matvec.sv]
`default_nettype none

module rppt_matvec #(
  parameter int unsigned VecWidth  = 21,
  parameter int unsigned CoefWidth = 18
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [9*CoefWidth-1:0]       mat_i,
  input  wire logic [3*VecWidth-1:0]        vec_i,
  output logic                              valid_o,
  output logic [3*(VecWidth+6)-1:0]         sum_o
);

  localparam int unsigned ProdW = CoefWidth + VecWidth;
  localparam int unsigned AccW  = ProdW + 2;
  localparam int unsigned SumW  = VecWidth + 6;
  localparam int unsigned Frac  = CoefWidth - 4;
  localparam logic signed [AccW-1:0] RoundBias = AccW'(1) << (Frac - 1);

  logic signed [ProdW-1:0] prod_q [9];
  logic                    valid_q;

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          prod_q[i*3+j] <= $signed(mat_i[(i*3+j)*CoefWidth +: CoefWidth])
                         * $signed(vec_i[j*VecWidth +: VecWidth]);
        end
      end
    end

    logic signed [AccW-1:0] acc;
    always_comb begin
      acc = AccW'(prod_q[i*3]) + AccW'(prod_q[i*3+1]) + AccW'(prod_q[i*3+2]) + RoundBias;
      sum_o[i*SumW +: SumW] = SumW'(acc >>> Frac);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

[rtl/core/relative_pose_point_transform.sv]
`default_nettype none

// Points pass the four-stage pipeline from the slave side to the master side
// (two multiply stages, each followed by a sum-and-round stage), one point
// per cycle while m_axis_tready does not hold the output back.
// Reset clears all valid bits and loads identity rotations and zero translations.

module relative_pose_point_transform #(
  parameter int unsigned COORD_WIDTH = rppt_pkg::COORD_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH  = rppt_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // px, py, pz
  input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // qx, qy, qz
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
  // clipped
  output logic [0:0]                                 m_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [rppt_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  wire logic [rppt_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic [rppt_pkg::APB_DATA_WIDTH-1:0]        prdata,
  output logic                                       pready
);

  import rppt_pkg::*;

  localparam int unsigned PW     = COORD_WIDTH;
  localparam int unsigned CW     = COEF_WIDTH;
  localparam int unsigned TdataW = ((3*PW+7)/8)*8;
  localparam int unsigned Sum1W  = PW + 6;
  localparam int unsigned DW     = PW + 7;
  localparam int unsigned Sum2W  = DW + 6;
  localparam int unsigned RowW   = 3*CW;
  localparam int unsigned TrW    = 3*PW;
  localparam logic [RowW-1:0] IdRow0 = RowW'(1) << (CW - 4);
  localparam logic [RowW-1:0] IdRow1 = RowW'(1) << (CW - 4 + CW);
  localparam logic [RowW-1:0] IdRow2 = RowW'(1) << (CW - 4 + 2*CW);

  logic [RowW-1:0] rot_q [3];
  logic [RowW-1:0] inv_q [3];
  logic [TrW-1:0]  tc_q;
  logic [TrW-1:0]  tp_q;

  logic [REG_IDX_WIDTH-1:0] reg_idx;
  logic                     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_WIDTH-1:APB_ADDR_WIDTH-REG_IDX_WIDTH];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0] <= IdRow0;
      rot_q[1] <= IdRow1;
      rot_q[2] <= IdRow2;
      inv_q[0] <= IdRow0;
      inv_q[1] <= IdRow1;
      inv_q[2] <= IdRow2;
      tc_q     <= '0;
      tp_q     <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROT_CURR_ROW0: rot_q[0] <= pwdata[RowW-1:0];
        REG_ROT_CURR_ROW1: rot_q[1] <= pwdata[RowW-1:0];
        REG_ROT_CURR_ROW2: rot_q[2] <= pwdata[RowW-1:0];
        REG_TRANS_CURR:    tc_q     <= pwdata[TrW-1:0];
        REG_TRANS_PREV:    tp_q     <= pwdata[TrW-1:0];
        REG_INV_PREV_ROW0: inv_q[0] <= pwdata[RowW-1:0];
        REG_INV_PREV_ROW1: inv_q[1] <= pwdata[RowW-1:0];
        REG_INV_PREV_ROW2: inv_q[2] <= pwdata[RowW-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROT_CURR_ROW0: prdata = APB_DATA_WIDTH'(rot_q[0]);
      REG_ROT_CURR_ROW1: prdata = APB_DATA_WIDTH'(rot_q[1]);
      REG_ROT_CURR_ROW2: prdata = APB_DATA_WIDTH'(rot_q[2]);
      REG_TRANS_CURR:    prdata = APB_DATA_WIDTH'(tc_q);
      REG_TRANS_PREV:    prdata = APB_DATA_WIDTH'(tp_q);
      REG_INV_PREV_ROW0: prdata = APB_DATA_WIDTH'(inv_q[0]);
      REG_INV_PREV_ROW1: prdata = APB_DATA_WIDTH'(inv_q[1]);
      REG_INV_PREV_ROW2: prdata = APB_DATA_WIDTH'(inv_q[2]);
      default:           prdata = '0;
    endcase
  end

  // stage enables: a stage advances when empty or when its successor advances
  logic en_m1, en_d, en_m2, en_out;
  logic v_m1, v_m2, v_d_q, v_out_q;

  assign en_out        = !v_out_q || m_axis_tready;
  assign en_m2         = !v_m2 || en_out;
  assign en_d          = !v_d_q || en_m2;
  assign en_m1         = !v_m1 || en_d;
  assign s_axis_tready = en_m1;

  // first rotation
  logic [3*Sum1W-1:0] sum1;

  rppt_matvec #(
    .VecWidth  (PW),
    .CoefWidth (CW)
  ) u_rot_curr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_m1),
    .valid_i (s_axis_tvalid),
    .mat_i   ({rot_q[2], rot_q[1], rot_q[0]}),
    .vec_i   (s_axis_tdata[3*PW-1:0]),
    .valid_o (v_m1),
    .sum_o   (sum1)
  );

  // translate
  logic [3*DW-1:0] d_q;

  for (genvar i = 0; i < 3; i++) begin : g_trans
    logic signed [DW-1:0] d_d;
    always_comb begin
      d_d = DW'($signed(sum1[i*Sum1W +: Sum1W]))
          + DW'($signed(tc_q[i*PW +: PW]))
          - DW'($signed(tp_q[i*PW +: PW]));
    end
    always_ff @(posedge clk_i) begin
      if (en_d) begin
        d_q[i*DW +: DW] <= d_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_d_q <= 1'b0;
    end else if (en_d) begin
      v_d_q <= v_m1;
    end
  end

  // inverse previous rotation
  logic [3*Sum2W-1:0] sum2;

  rppt_matvec #(
    .VecWidth  (DW),
    .CoefWidth (CW)
  ) u_inv_prev (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_m2),
    .valid_i (v_d_q),
    .mat_i   ({inv_q[2], inv_q[1], inv_q[0]}),
    .vec_i   (d_q),
    .valid_o (v_m2),
    .sum_o   (sum2)
  );

  // saturate
  logic [3*PW-1:0] q_d, q_q;
  logic [2:0]      ovf;
  logic            clip_q;

  for (genvar i = 0; i < 3; i++) begin : g_sat
    logic [Sum2W-1:0]    r;
    logic [Sum2W-PW:0]   upper;
    always_comb begin
      r      = sum2[i*Sum2W +: Sum2W];
      upper  = r[Sum2W-1:PW-1];
      ovf[i] = !((&upper) || !(|upper));
      if (ovf[i]) begin
        q_d[i*PW +: PW] = r[Sum2W-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
      end else begin
        q_d[i*PW +: PW] = r[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      q_q    <= q_d;
      clip_q <= |ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_out_q <= 1'b0;
    end else if (en_out) begin
      v_out_q <= v_m2;
    end
  end

  assign m_axis_tvalid = v_out_q;
  assign m_axis_tdata  = TdataW'(q_q);
  assign m_axis_tuser  = clip_q;

endmodule

`default_nettype wire

[verif/tb_relative_pose_point_transform.sv]
`timescale 1ns / 100ps

module tb_relative_pose_point_transform;
  import rppt_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int KW = COEF_WIDTH_DEF;
  localparam int FRAC = KW - 4;
  localparam int TDW = ((3 * CW + 7) / 8) * 8;
  localparam int LATENCY = 4;
  localparam int STALL_LIMIT = 2000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [KW-1:0] coef_t;

  typedef struct packed {
    logic   clipped;
    coord_t qz;
    coord_t qy;
    coord_t qx;
  } pose_point_t;

  localparam coord_t C_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(CW - 1){1'b0}}};
  localparam coef_t  K_MAX = {1'b0, {(KW - 1){1'b1}}};
  localparam coef_t  K_MIN = {1'b1, {(KW - 1){1'b0}}};
  localparam coef_t  K_ONE = coef_t'(1 << FRAC);
  localparam coef_t  K_HALF = coef_t'(1 << (FRAC - 1));

  class relpose_checker;
    longint rot_c[3][3];
    longint inv_p[3][3];
    longint t_c[3];
    longint t_p[3];
    pose_point_t pending_q[$];
    int errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rot_c[i][j] = (i == j) ? K_ONE : 0;
          inv_p[i][j] = (i == j) ? K_ONE : 0;
        end
        t_c[i] = 0;
        t_p[i] = 0;
      end
      errors = 0;
    endfunction

    function void note_write(logic [REG_IDX_WIDTH-1:0] idx, logic [63:0] v);
      coef_t  k;
      coord_t c;
      for (int j = 0; j < 3; j++) begin
        k = v[j*KW +: KW];
        c = v[j*CW +: CW];
        case (idx)
          REG_ROT_CURR_ROW0: rot_c[0][j] = k;
          REG_ROT_CURR_ROW1: rot_c[1][j] = k;
          REG_ROT_CURR_ROW2: rot_c[2][j] = k;
          REG_TRANS_CURR:    t_c[j] = c;
          REG_TRANS_PREV:    t_p[j] = c;
          REG_INV_PREV_ROW0: inv_p[0][j] = k;
          REG_INV_PREV_ROW1: inv_p[1][j] = k;
          REG_INV_PREV_ROW2: inv_p[2][j] = k;
          default: ;
        endcase
      end
    endfunction

    function longint round_q(longint v);
      return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function pose_point_t map_point(logic [TDW-1:0] data);
      longint p[3];
      longint d[3];
      longint acc;
      longint r;
      coord_t c;
      coord_t q[3];
      pose_point_t res;
      res.clipped = 1'b0;
      for (int j = 0; j < 3; j++) begin
        c = data[j*CW +: CW];
        p[j] = c;
      end
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += rot_c[i][j] * p[j];
        d[i] = round_q(acc) + t_c[i] - t_p[i];
      end
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += inv_p[i][j] * d[j];
        r = round_q(acc);
        if (r > C_MAX) begin
          r = C_MAX;
          res.clipped = 1'b1;
        end else if (r < C_MIN) begin
          r = C_MIN;
          res.clipped = 1'b1;
        end
        q[i] = coord_t'(r);
      end
      res.qx = q[0];
      res.qy = q[1];
      res.qz = q[2];
      return res;
    endfunction

    function void note_point(logic [TDW-1:0] data);
      pending_q.push_back(map_point(data));
    endfunction

    function void check_point(logic [TDW-1:0] data, logic clipped);
      pose_point_t want;
      coord_t want_q[3];
      coord_t got_q[3];
      string   axis[3];
      axis = '{"qx", "qy", "qz"};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual data %h clipped %b",
                 $time, data, clipped);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      want_q = '{want.qx, want.qy, want.qz};
      for (int j = 0; j < 3; j++) begin
        got_q[j] = data[j*CW +: CW];
        if (got_q[j] !== want_q[j]) begin
          $display("%0t: %s expected %0d actual %0d", $time, axis[j], want_q[j], got_q[j]);
          errors++;
        end
      end
      if (clipped !== want.clipped) begin
        $display("%0t: clipped expected %b actual %b", $time, want.clipped, clipped);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // px, py, pz
  logic [TDW-1:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // qx, qy, qz
  logic [TDW-1:0] m_tdata;
  // clipped
  logic [0:0] m_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0] paddr = '0;
  logic [APB_DATA_WIDTH-1:0] pwdata = '0;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic pready;

  relpose_checker sb = new();
  bit src_calm = 1'b0;
  int idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  relative_pose_point_transform u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_tdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  function automatic coord_t rand_coord();
    coord_t pick[5];
    pick = '{C_MIN, C_MAX, 0, -1, 1};
    if ($urandom_range(0, 4) == 0) return pick[$urandom_range(0, 4)];
    return coord_t'($urandom);
  endfunction

  function automatic logic [63:0] coef_word(coef_t c0, coef_t c1, coef_t c2, logic [63:0] fill);
    fill[3*KW-1:0] = {c2, c1, c0};
    return fill;
  endfunction

  function automatic logic [63:0] trans_word(coord_t x, coord_t y, coord_t z,
                                             logic [63:0] fill);
    fill[3*CW-1:0] = {z, y, x};
    return fill;
  endfunction

  function automatic logic [63:0] rand_word(bit is_trans, bit modest);
    logic [63:0] w;
    w = {$urandom, $urandom};
    if (modest) begin
      for (int j = 0; j < 3; j++) begin
        if (is_trans) w[j*CW +: CW] = coord_t'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
        else w[j*KW +: KW] = coef_t'(int'($urandom_range(0, 32768)) - 16384);
      end
    end
    return w;
  endfunction

  task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
    int gap;
    if ($urandom_range(0, 31) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(TDW - 3 * CW){1'b0}}, z, y, x};
    do @(posedge clk_i); while (s_tready !== 1'b1);
    sb.note_point(s_tdata);
  endtask

  task automatic send_extremes();
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(C_MAX, C_MIN, 0);
    send_point(1, -1, C_MIN);
  endtask

  // hold off until every pending point has come out of the pipeline
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic program_pose(input logic [63:0] vals [8]);
    settle();
    for (int i = 0; i < 8; i++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= APB_ADDR_WIDTH'(i * 8);
      pwdata <= vals[i];
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (pready !== 1'b1);
      sb.note_write(REG_IDX_WIDTH'(i), vals[i]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : result_sink
    int  stall;
    bit  calm;
    calm = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 31) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (m_tvalid !== 1'b1);
      sb.check_point(m_tdata, m_tuser[0]);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("relative_pose_point_transform: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0] cfg [8];
    bit modest;
    bit is_trans;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_extremes();
    send_point(0, 0, 0);
    send_point(1, 2, 3);
    send_point(-1, -2, -3);
    send_point(C_MIN, C_MAX, -1);

    // largest coefficients and opposite translations, junk in the unused high bits
    for (int i = 0; i < 8; i++) cfg[i] = coef_word(K_MAX, K_MAX, K_MAX, '1);
    cfg[REG_TRANS_CURR] = trans_word(C_MAX, C_MAX, C_MAX, '1);
    cfg[REG_TRANS_PREV] = trans_word(C_MIN, C_MIN, C_MIN, '0);
    program_pose(cfg);
    send_extremes();

    for (int i = 0; i < 8; i++) cfg[i] = coef_word(K_MIN, K_MIN, K_MIN, '0);
    cfg[REG_TRANS_CURR] = trans_word(C_MIN, C_MIN, C_MIN, '0);
    cfg[REG_TRANS_PREV] = trans_word(C_MAX, C_MAX, C_MAX, '0);
    program_pose(cfg);
    send_extremes();

    // half-scale rotation puts odd coordinates exactly on rounding ties
    cfg[REG_ROT_CURR_ROW0] = coef_word(K_HALF, 0, 0, '0);
    cfg[REG_ROT_CURR_ROW1] = coef_word(0, K_HALF, 0, '0);
    cfg[REG_ROT_CURR_ROW2] = coef_word(0, 0, K_HALF, '0);
    cfg[REG_TRANS_CURR] = '0;
    cfg[REG_TRANS_PREV] = '0;
    cfg[REG_INV_PREV_ROW0] = coef_word(K_ONE, 0, 0, '0);
    cfg[REG_INV_PREV_ROW1] = coef_word(0, K_ONE, 0, '0);
    cfg[REG_INV_PREV_ROW2] = coef_word(0, 0, K_ONE, '0);
    program_pose(cfg);
    send_point(1, -1, 3);
    send_point(-3, 5, -5);
    send_point(C_MAX, C_MIN, 1);

    for (int ph = 0; ph < 10; ph++) begin
      modest = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < 8; i++) begin
        is_trans = (REG_IDX_WIDTH'(i) == REG_TRANS_CURR) ||
                   (REG_IDX_WIDTH'(i) == REG_TRANS_PREV);
        cfg[i] = rand_word(is_trans, modest);
      end
      program_pose(cfg);
      for (int k = 0; k < 98; k++) send_point(rand_coord(), rand_coord(), rand_coord());
    end

    settle();
    repeat (4 * LATENCY) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("relative_pose_point_transform: match");
    else
      $display("relative_pose_point_transform: mismatch");
    $finish;
  end

endmodule
